### src/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_pkg
// shared sizes, types and slot helpers of the ring buffer deque
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int MODE_W        = 3;
    localparam int PUSH_VALUE_W  = 32;
    localparam int READ_VALUE_W  = 32;
    localparam int ENTRY_COUNT_W = 7;
    localparam int STATUS_W      = 2;

    typedef logic [DATA_WIDTH-1:0]    data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [IDX_W:0]           gap_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [READ_VALUE_W-1:0]  read_value_t;
    typedef logic [ENTRY_COUNT_W-1:0] entry_count_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_READ_FRONT = 3'd4,
        MODE_READ_BACK  = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // command to the row of cells
    typedef struct packed {
        logic  shift_left;
        logic  shift_right;
        logic  load;
        data_t load_data;
    } ring_cmd_t;

    function automatic idx_t next_slot(input idx_t i);
        idx_t r;
        if (i == idx_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic idx_t prev_slot(input idx_t i);
        idx_t r;
        if (i == '0)
        begin
            r = idx_t'(DEPTH - 1);
        end
        else
        begin
            r = i - idx_t'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/rbd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_req_if / rbd_rsp_if
// valid/ready channels for request and response words of the deque
// ----------------------------------------------------------------------------
interface rbd_req_if;
    logic                             valid;
    logic                             ready;
    logic [rbd_pkg::MODE_W-1:0]       mode;
    logic [rbd_pkg::PUSH_VALUE_W-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface rbd_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [rbd_pkg::READ_VALUE_W-1:0]  read_value;
    logic [rbd_pkg::ENTRY_COUNT_W-1:0] entry_count;
    logic [rbd_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output read_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input entry_count, input status,
                    output ready);
endinterface
`default_nettype wire

### src/ring_buffer_deque_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit
// double-ended queue of DEPTH words held in a rotating ring of cells
// ----------------------------------------------------------------------------
// req carries one operation word (mode, push_value); rsp returns one word
// (read_value, entry_count, status) for every request, in order.
// the store is a closed ring of cells; only cell 0 is read or written. the
// ring turns one slot per cycle, in the shorter direction, until the slot
// that the operation needs sits in cell 0.
// a refused push/pop/read or an unused mode answers straight from idle;
// any other operation first turns the ring by d slots, where d is the ring
// distance from the slot at cell 0 to the target slot, 0 <= d <= DEPTH/2.
// no new request is taken before the previous one is answered; it is taken
// as or after the previous response is taken, so the output register never stalls the ring.
// reset clears indices, count and handshakes; the cell contents stay
// undefined and are only read after a push wrote them.
// a stalled receiver holds the response word; no new request is taken
// until it is accepted.
// ----------------------------------------------------------------------------
module ring_buffer_deque_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    rbd_req_if.sink   req,
    rbd_rsp_if.source rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_SEEK
    } state_t;

    state_t                 state_reg,     state_next;
    rbd_pkg::idx_t          front_reg,     front_next;
    rbd_pkg::idx_t          back_reg,      back_next;
    rbd_pkg::cnt_t          count_reg,     count_next;
    rbd_pkg::idx_t          pos_reg,       pos_next;
    rbd_pkg::idx_t          target_reg,    target_next;
    rbd_pkg::mode_t         op_reg,        op_next;
    rbd_pkg::data_t         value_reg,     value_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rbd_pkg::read_value_t   rsp_data_reg,  rsp_data_next;
    rbd_pkg::entry_count_t  rsp_count_reg, rsp_count_next;
    rbd_pkg::status_t       rsp_stat_reg,  rsp_stat_next;

    rbd_pkg::ring_cmd_t     cmd;
    rbd_pkg::data_t         head;
    rbd_pkg::mode_t         mode_in;
    rbd_pkg::gap_t          gap;
    logic                   accept;
    logic                   full;
    logic                   empty;

    rbd_ring u_ring (
        .clk  (clk),
        .cmd  (cmd),
        .head (head)
    );

    assign mode_in = rbd_pkg::mode_t'(req.mode);
    assign full    = (count_reg == rbd_pkg::cnt_t'(rbd_pkg::DEPTH));
    assign empty   = (count_reg == '0);
    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept  = req.valid && req.ready;

    // ring distance from the slot at the head to the target slot
    always_comb
    begin
        if (target_reg >= pos_reg)
        begin
            gap = {1'b0, target_reg} - {1'b0, pos_reg};
        end
        else
        begin
            gap = {1'b0, target_reg} + rbd_pkg::gap_t'(rbd_pkg::DEPTH)
                  - {1'b0, pos_reg};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_count_next = rsp_count_reg;
        rsp_stat_next  = rsp_stat_reg;

        cmd.shift_left  = 1'b0;
        cmd.shift_right = 1'b0;
        cmd.load        = 1'b0;
        cmd.load_data   = value_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = mode_in;
                    value_next = rbd_pkg::data_t'(req.push_value);
                    rsp_data_next  = '0;
                    rsp_count_next = rbd_pkg::entry_count_t'(count_reg);
                    rsp_stat_next  = rbd_pkg::STATUS_OK;
                    case (mode_in)
                        rbd_pkg::MODE_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_stat_next  = rbd_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                target_next = back_reg;
                                state_next  = ST_SEEK;
                            end
                        end
                        rbd_pkg::MODE_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_stat_next  = rbd_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                target_next = rbd_pkg::prev_slot(front_reg);
                                state_next  = ST_SEEK;
                            end
                        end
                        rbd_pkg::MODE_POP_BACK,
                        rbd_pkg::MODE_READ_BACK:
                        begin
                            if (empty)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_stat_next  = rbd_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                target_next = rbd_pkg::prev_slot(back_reg);
                                state_next  = ST_SEEK;
                            end
                        end
                        rbd_pkg::MODE_POP_FRONT,
                        rbd_pkg::MODE_READ_FRONT:
                        begin
                            if (empty)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_stat_next  = rbd_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                target_next = front_reg;
                                state_next  = ST_SEEK;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_SEEK:
            begin
                if (pos_reg == target_reg)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_stat_next  = rbd_pkg::STATUS_OK;
                    rsp_data_next  = '0;
                    state_next     = ST_IDLE;
                    case (op_reg)
                        rbd_pkg::MODE_PUSH_BACK:
                        begin
                            cmd.load   = 1'b1;
                            back_next  = rbd_pkg::next_slot(back_reg);
                            count_next = count_reg + rbd_pkg::cnt_t'(1);
                        end
                        rbd_pkg::MODE_PUSH_FRONT:
                        begin
                            cmd.load   = 1'b1;
                            front_next = target_reg;
                            count_next = count_reg + rbd_pkg::cnt_t'(1);
                        end
                        rbd_pkg::MODE_POP_BACK:
                        begin
                            rsp_data_next = rbd_pkg::read_value_t'(head);
                            back_next     = target_reg;
                            count_next    = count_reg - rbd_pkg::cnt_t'(1);
                        end
                        rbd_pkg::MODE_POP_FRONT:
                        begin
                            rsp_data_next = rbd_pkg::read_value_t'(head);
                            front_next    = rbd_pkg::next_slot(front_reg);
                            count_next    = count_reg - rbd_pkg::cnt_t'(1);
                        end
                        rbd_pkg::MODE_READ_FRONT,
                        rbd_pkg::MODE_READ_BACK:
                        begin
                            rsp_data_next = rbd_pkg::read_value_t'(head);
                        end
                        default:
                        begin
                            rsp_data_next = '0;
                        end
                    endcase
                    rsp_count_next = rbd_pkg::entry_count_t'(count_next);
                end
                else if (gap <= rbd_pkg::gap_t'(rbd_pkg::DEPTH / 2))
                begin
                    // cell i takes cell i+1, head moves to the next slot
                    cmd.shift_left = 1'b1;
                    pos_next       = rbd_pkg::next_slot(pos_reg);
                end
                else
                begin
                    cmd.shift_right = 1'b1;
                    pos_next        = rbd_pkg::prev_slot(pos_reg);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            target_reg    <= '0;
            op_reg        <= rbd_pkg::MODE_PUSH_BACK;
            value_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
            rsp_count_reg <= '0;
            rsp_stat_reg  <= rbd_pkg::STATUS_OK;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            op_reg        <= op_next;
            value_reg     <= value_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
            rsp_count_reg <= rsp_count_next;
            rsp_stat_reg  <= rsp_stat_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = rsp_data_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.status      = rsp_stat_reg;

endmodule
`default_nettype wire

### src/rbd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_cell
// one storage cell of the rotating ring, shifts left or right or loads
// ----------------------------------------------------------------------------
module rbd_cell (
    input  wire logic              clk,
    input  wire rbd_pkg::ring_cmd_t cmd,
    input  wire logic              load_en,
    input  wire rbd_pkg::data_t    prev_data,
    input  wire rbd_pkg::data_t    next_data,
    output rbd_pkg::data_t         q
);

    rbd_pkg::data_t data_reg;
    rbd_pkg::data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_left)
        begin
            data_next = next_data;
        end
        else if (cmd.shift_right)
        begin
            data_next = prev_data;
        end
        else if (cmd.load && load_en)
        begin
            data_next = cmd.load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule
`default_nettype wire

### src/rbd_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbd_ring
// closed row of cells; cell 0 is the head that is read and written
// ----------------------------------------------------------------------------
module rbd_ring (
    input  wire logic               clk,
    input  wire rbd_pkg::ring_cmd_t cmd,
    output rbd_pkg::data_t          head
);

    rbd_pkg::data_t cell_q [rbd_pkg::DEPTH];

    for (genvar i = 0; i < rbd_pkg::DEPTH; i++)
    begin : g_cell
        rbd_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .load_en   ((i == 0) ? 1'b1 : 1'b0),
            .prev_data (cell_q[(i + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH]),
            .next_data (cell_q[(i + 1) % rbd_pkg::DEPTH]),
            .q         (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule
`default_nettype wire

### test/ring_buffer_deque_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_unit_tb
// drives push, pop and read words into the deque under three idling
// phases, mirrors the ring in a scoreboard and checks every response word
// ----------------------------------------------------------------------------
module ring_buffer_deque_unit_tb;

    import rbd_pkg::*;

    localparam int RANDOM_ITEMS  = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_CYCLES  = DEPTH / 2 + 8;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

    typedef struct {
        read_value_t  read_value;
        entry_count_t entry_count;
        status_t      status;
    } deque_answer_t;

    class deque_mirror;
        data_t         slots [DEPTH];
        idx_t          front_slot = '0;
        idx_t          back_slot  = '0;
        cnt_t          held       = '0;
        deque_answer_t answers_due [$];
        int            mismatches = 0;

        function idx_t step_up(idx_t i);
            return (i == idx_t'(DEPTH - 1)) ? idx_t'(0) : idx_t'(i + 1'b1);
        endfunction

        function idx_t step_down(idx_t i);
            return (i == idx_t'(0)) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [PUSH_VALUE_W-1:0] v);
            deque_answer_t a;
            bit            full;
            bit            empty;
            a.read_value = '0;
            a.status     = STATUS_OK;
            full         = (held == cnt_t'(DEPTH));
            empty        = (held == cnt_t'(0));
            case (m)
                MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        a.status = STATUS_FULL;
                    end
                    else
                    begin
                        slots[back_slot] = data_t'(v);
                        back_slot = step_up(back_slot);
                        held++;
                    end
                end
                MODE_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        a.status = STATUS_FULL;
                    end
                    else
                    begin
                        front_slot = step_down(front_slot);
                        slots[front_slot] = data_t'(v);
                        held++;
                    end
                end
                MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        a.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        back_slot = step_down(back_slot);
                        a.read_value = read_value_t'(slots[back_slot]);
                        held--;
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        a.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        a.read_value = read_value_t'(slots[front_slot]);
                        front_slot = step_up(front_slot);
                        held--;
                    end
                end
                MODE_READ_FRONT:
                begin
                    if (empty)
                    begin
                        a.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        a.read_value = read_value_t'(slots[front_slot]);
                    end
                end
                MODE_READ_BACK:
                begin
                    if (empty)
                    begin
                        a.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        a.read_value = read_value_t'(slots[step_down(back_slot)]);
                    end
                end
                default:
                begin
                end
            endcase
            a.entry_count = entry_count_t'(held);
            answers_due.push_back(a);
        endfunction

        function void check_answer(read_value_t rd, entry_count_t cnt,
                                   logic [STATUS_W-1:0] st);
            deque_answer_t a;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected response word: read_value=%h entry_count=%0d status=%0d",
                             rd, cnt, st);
                end
                return;
            end
            a = answers_due.pop_front();
            if (rd !== a.read_value || cnt !== a.entry_count || st !== a.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("response mismatch at %0t: expected %h/%0d/%0d, got %h/%0d/%0d",
                             $realtime, a.read_value, a.entry_count, a.status, rd, cnt, st);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rbd_req_if req_ch ();
    rbd_rsp_if rsp_ch ();

    ring_buffer_deque_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deque_mirror sb = new;

    int tx_idle_pct = 19;
    int rx_idle_pct = 67;
    int stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // response side back-pressure
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            @(posedge clk);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                sb.note_request(req_ch.mode, req_ch.push_value);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_answer(rsp_ch.read_value, rsp_ch.entry_count, rsp_ch.status);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("ring_buffer_deque_unit_tb failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] m, input logic [PUSH_VALUE_W-1:0] v);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.push_value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    initial
    begin
        int                      i;
        int                      r;
        int                      seg;
        int                      push_lim;
        int                      pop_lim;
        int                      read_lim;
        logic [MODE_W-1:0]       m;
        logic [PUSH_VALUE_W-1:0] v;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= '0;
        req_ch.push_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // refusals on the empty deque and the unused modes
        send_word(MODE_READ_FRONT, $urandom);
        send_word(MODE_READ_BACK, $urandom);
        send_word(MODE_POP_BACK, $urandom);
        send_word(MODE_POP_FRONT, $urandom);
        send_word(MODE_UNUSED_LO, $urandom);
        send_word(MODE_UNUSED_HI, $urandom);
        // both ends, front index wraps below slot zero
        send_word(MODE_PUSH_BACK, 32'h0000_0000);
        send_word(MODE_PUSH_BACK, 32'hffff_ffff);
        send_word(MODE_PUSH_FRONT, 32'ha5a5_a5a5);
        send_word(MODE_PUSH_FRONT, 32'h5a5a_5a5a);
        send_word(MODE_PUSH_BACK, $urandom);
        send_word(MODE_READ_FRONT, $urandom);
        send_word(MODE_READ_BACK, $urandom);
        send_word(MODE_UNUSED_LO, $urandom);
        send_word(MODE_UNUSED_HI, $urandom);
        send_word(MODE_POP_FRONT, $urandom);
        send_word(MODE_POP_BACK, $urandom);
        send_word(MODE_POP_FRONT, $urandom);
        send_word(MODE_POP_BACK, $urandom);
        send_word(MODE_POP_BACK, $urandom);
        send_word(MODE_POP_FRONT, $urandom);
        // single word seen from both ends
        send_word(MODE_PUSH_FRONT, $urandom);
        send_word(MODE_READ_BACK, $urandom);
        send_word(MODE_READ_FRONT, $urandom);
        send_word(MODE_POP_BACK, $urandom);

        // fill, drain and mixed segments so both full and empty get hit
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 67;
                rx_idle_pct = 19;
            end
            if (i == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            seg = (i / 100) % 3;
            if (seg == 0)
            begin
                push_lim = 85;
                pop_lim  = 92;
                read_lim = 98;
            end
            else if (seg == 1)
            begin
                push_lim = 7;
                pop_lim  = 92;
                read_lim = 98;
            end
            else
            begin
                push_lim = 45;
                pop_lim  = 85;
                read_lim = 97;
            end
            r = $urandom_range(99);
            if (r < push_lim)
            begin
                m = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end
            else if (r < pop_lim)
            begin
                m = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_BACK;
            end
            else if (r < read_lim)
            begin
                m = $urandom_range(1) ? MODE_READ_FRONT : MODE_READ_BACK;
            end
            else
            begin
                m = $urandom_range(1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
            end
            r = $urandom_range(7);
            if (r == 0)
            begin
                v = '0;
            end
            else if (r == 1)
            begin
                v = '1;
            end
            else
            begin
                v = $urandom;
            end
            send_word(m, v);
        end
        req_ch.valid <= 1'b0;

        while (sb.answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.answers_due.size() == 0)
        begin
            $display("ring_buffer_deque_unit_tb passed");
        end
        else
        begin
            $display("ring_buffer_deque_unit_tb failed");
        end
        $finish;
    end

endmodule
